/* rtl/windowed_quota_accounting_macros.svh */
// ----------------------------------------------------------------------------
// Windowed quota accounting assertion macros
// Shared checks for the quota accounting block, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_QUOTA_ACCOUNTING_MACROS_SVH
`define WINDOWED_QUOTA_ACCOUNTING_MACROS_SVH

// same-cycle implication
`define WQA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WQA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wqa_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed quota accounting package
// Sizes, command and register codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package wqa_pkg;

  localparam int NUM_INTERVALS = 4;
  localparam int NUM_RESOURCES = 8;
  localparam int IV_W          = 2;
  localparam int RS_W          = 3;
  localparam int ADDR_W        = IV_W + RS_W;
  localparam int DEPTH         = NUM_INTERVALS * NUM_RESOURCES;
  localparam int CNT_W         = 64;
  localparam int NOW_W         = 48;
  localparam int DUR_W         = 40;
  localparam int FUNC_W        = 3;
  localparam int ICNT_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 40;
  localparam int DIV_CNT_W     = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_USE,
    FN_CHECK,
    FN_CHECK_ALL,
    FN_WRITE_LIMIT,
    FN_READ_USAGE
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL_COUNT,
    CFG_DURATION_ZERO,
    CFG_DURATION_ONE,
    CFG_DURATION_TWO,
    CFG_DURATION_THREE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOP,
    ST_EVAL,
    ST_DIV,
    ST_ADV,
    ST_RADV,
    ST_RDREQ,
    ST_RDRSP,
    ST_WLIM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             exceeded;
    logic [IV_W-1:0]  hit_interval;
    logic [RS_W-1:0]  hit_resource;
    logic [CNT_W-1:0] used_value;
    logic [CNT_W-1:0] limit_value;
    logic [NOW_W-1:0] window_end;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/wqa_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one quota command.
// ----------------------------------------------------------------------------
interface wqa_req_if
  import wqa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RS_W-1:0]   resource;
  logic [IV_W-1:0]   interval_sel;
  logic [CNT_W-1:0]  amount;
  logic [NOW_W-1:0]  now;
  logic              check_en;

  modport source (output valid, func, resource, interval_sel, amount, now, check_en,
                  input ready);
  modport sink (input valid, func, resource, interval_sel, amount, now, check_en,
                output ready);
endinterface

/* rtl/wqa_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one quota result.
// ----------------------------------------------------------------------------
interface wqa_rsp_if
  import wqa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             exceeded;
  logic [IV_W-1:0]  hit_interval;
  logic [RS_W-1:0]  hit_resource;
  logic [CNT_W-1:0] used_value;
  logic [CNT_W-1:0] limit_value;
  logic [NOW_W-1:0] window_end;

  modport source (output valid, exceeded, hit_interval, hit_resource, used_value,
                  limit_value, window_end, input ready);
  modport sink (input valid, exceeded, hit_interval, hit_resource, used_value,
                limit_value, window_end, output ready);
endinterface

/* rtl/wqa_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write: index and data.
// ----------------------------------------------------------------------------
interface wqa_cfg_if
  import wqa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wqa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wqa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/wqa_div.sv */
// ----------------------------------------------------------------------------
// Window remainder unit
// Restoring division, one numerator bit a cycle; delivers num mod den.
// ----------------------------------------------------------------------------
module wqa_div
  import wqa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NOW_W-1:0] num,
  input  logic [DUR_W-1:0] den,
  output div_stat_t        stat,
  output logic [DUR_W-1:0] rem
);
  logic [NOW_W-1:0]     sh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DUR_W:0]       trial;

  assign trial = {rem, sh[NOW_W-1]};
  assign stat  = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NOW_W - 1);
        sh   <= num;
        rem  <= '0;
      end else if (busy) begin
        sh <= {sh[NOW_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= DUR_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[DUR_W-1:0];
        end
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/windowed_quota_accounting.sv */
// ----------------------------------------------------------------------------
// Windowed quota accounting
// One command at a time; the request port is ready only while idle. Usage
// counters and limits live in two 32-entry RAMs with registered read data.
// A command walks the active intervals (all eight resources for check all);
// each expired window that is over its limit, and each expired window on a
// read usage, takes a pass through the bit-serial remainder unit.
// No clearing pass after reset: per-entry valid bits stand in for zeroed counters.
// ----------------------------------------------------------------------------
`include "windowed_quota_accounting_macros.svh"

module windowed_quota_accounting
  import wqa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wqa_req_if.sink   req,
  wqa_rsp_if.source rsp,
  wqa_cfg_if.sink   cfg
);
  state_t state, state_next;

  logic [ICNT_W-1:0] interval_count;
  logic [DUR_W-1:0]  dur [NUM_INTERVALS];
  logic [NOW_W-1:0]  wend [NUM_INTERVALS];
  logic [DEPTH-1:0]  uvalid;
  logic [DEPTH-1:0]  lvalid;

  logic [FUNC_W-1:0] func_q;
  logic [RS_W-1:0]   rr;
  logic [IV_W-1:0]   sel_q;
  logic [CNT_W-1:0]  amt_q;
  logic [NOW_W-1:0]  now_q;
  logic              chk_q;
  logic [ICNT_W-1:0] idx;
  logic [CNT_W-1:0]  lim_q;
  rsp_t              res;
  rsp_t              out_q;
  logic              out_valid;

  logic [ICNT_W-1:0] n_act;
  logic [IV_W-1:0]   iv;
  logic [ADDR_W-1:0] loop_addr;
  logic [ADDR_W-1:0] sel_addr;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] cur_addr;
  logic [CNT_W-1:0]  u_rd, l_rd, u_cur, l_cur, sum;
  logic [DUR_W-1:0]  d_eff;
  logic [NOW_W-1:0]  end_i, new_end;
  logic              expired, in_range, over_use, over_chk, out_free, accept;
  logic              u_we, l_we, div_start, res_load;
  logic [CNT_W-1:0]  u_wdata;
  rsp_t              res_val;
  div_stat_t         div_stat;
  logic [DUR_W-1:0]  div_rem;

  assign n_act     = (interval_count > ICNT_W'(NUM_INTERVALS)) ? ICNT_W'(NUM_INTERVALS)
                                                              : interval_count;
  assign iv        = idx[IV_W-1:0];
  assign loop_addr = {iv, rr};
  assign sel_addr  = {sel_q, rr};
  assign raddr     = (state == ST_RDREQ) ? sel_addr : loop_addr;
  assign cur_addr  = (state == ST_RDRSP) ? sel_addr : loop_addr;
  assign u_cur     = uvalid[cur_addr] ? u_rd : '0;
  assign l_cur     = lvalid[cur_addr] ? l_rd : '0;
  assign sum       = u_cur + amt_q;
  assign d_eff     = (dur[iv] == '0) ? DUR_W'(1) : dur[iv];
  assign end_i     = wend[iv];
  assign expired   = now_q >= end_i;
  assign in_range  = idx < n_act;
  assign over_use  = (l_cur != '0) && (sum > l_cur);
  assign over_chk  = (l_cur != '0) && (u_cur > l_cur);
  assign new_end   = NOW_W'(now_q + NOW_W'(d_eff) - NOW_W'(div_rem));
  assign out_free  = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign req.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready = !rst;

  wqa_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_usage_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (loop_addr),
    .wdata (u_wdata),
    .raddr (raddr),
    .rdata (u_rd)
  );

  wqa_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_limit_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (sel_addr),
    .wdata (amt_q),
    .raddr (raddr),
    .rdata (l_rd)
  );

  wqa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NOW_W'(now_q - end_i)),
    .den   (d_eff),
    .stat  (div_stat),
    .rem   (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (req.func == FN_WRITE_LIMIT) begin
            state_next = ST_WLIM;
          end else if (req.func == FN_READ_USAGE) begin
            state_next = ST_RADV;
          end else if (req.func == FN_USE || req.func == FN_CHECK ||
                       req.func == FN_CHECK_ALL) begin
            state_next = ST_LOOP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LOOP: begin
        if (in_range) begin
          state_next = ST_EVAL;
        end else if (!(func_q == FN_CHECK_ALL && rr != RS_W'(NUM_RESOURCES - 1))) begin
          state_next = ST_DONE;
        end
      end
      ST_EVAL: begin
        if (func_q == FN_USE) begin
          priority if (over_use && expired) begin
            state_next = ST_DIV;
          end else if (over_use && chk_q) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_LOOP;
          end
        end else begin
          priority if (!over_chk) begin
            state_next = ST_LOOP;
          end else if (!expired) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        priority if (func_q == FN_READ_USAGE) begin
          state_next = ST_RADV;
        end else if (func_q == FN_USE && chk_q && amt_q > lim_q) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_RADV: begin
        priority if (!in_range) begin
          state_next = ST_RDREQ;
        end else if (expired) begin
          state_next = ST_DIV;
        end
      end
      ST_RDREQ: state_next = ST_RDRSP;
      ST_RDRSP: state_next = ST_DONE;
      ST_WLIM:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    u_we      = 1'b0;
    u_wdata   = sum;
    l_we      = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    res_val   = '{exceeded: 1'b1, hit_interval: iv, hit_resource: rr, used_value: sum,
                  limit_value: l_cur, window_end: end_i};
    unique case (state)
      ST_EVAL: begin
        if (func_q == FN_USE) begin
          if (over_use && expired) begin
            div_start = 1'b1;
          end else begin
            u_we     = 1'b1;
            res_load = over_use && chk_q;
          end
        end else if (over_chk) begin
          div_start          = expired;
          res_load           = !expired;
          res_val.used_value = u_cur;
        end
      end
      ST_ADV: begin
        if (func_q == FN_USE) begin
          u_we                = 1'b1;
          u_wdata             = amt_q;
          res_load            = chk_q && amt_q > lim_q;
          res_val.used_value  = amt_q;
          res_val.limit_value = lim_q;
          res_val.window_end  = new_end;
        end
      end
      ST_RADV: begin
        div_start = in_range && expired;
      end
      ST_RDRSP: begin
        res_load             = 1'b1;
        res_val.exceeded     = 1'b0;
        res_val.hit_interval = sel_q;
        res_val.used_value   = u_cur;
        res_val.window_end   = wend[sel_q];
      end
      ST_WLIM: begin
        l_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      interval_count <= '0;
      uvalid         <= '0;
      lvalid         <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_INTERVALS; i++) begin
        dur[i]  <= DUR_W'(1);
        wend[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_INTERVAL_COUNT: interval_count <= cfg.data[ICNT_W-1:0];
          CFG_DURATION_ZERO:  dur[0] <= cfg.data[DUR_W-1:0];
          CFG_DURATION_ONE:   dur[1] <= cfg.data[DUR_W-1:0];
          CFG_DURATION_TWO:   dur[2] <= cfg.data[DUR_W-1:0];
          CFG_DURATION_THREE: dur[3] <= cfg.data[DUR_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == ST_ADV) begin
        wend[iv] <= new_end;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          if (!(u_we && RS_W'(r) == rr)) begin
            uvalid[{iv, RS_W'(r)}] <= 1'b0;
          end
        end
      end
      if (u_we) begin
        uvalid[loop_addr] <= 1'b1;
      end
      if (l_we) begin
        lvalid[sel_addr] <= 1'b1;
      end

      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= req.func;
      rr     <= (req.func == FN_CHECK_ALL) ? '0 : req.resource;
      sel_q  <= req.interval_sel;
      amt_q  <= req.amount;
      now_q  <= req.now;
      chk_q  <= req.check_en;
      idx    <= '0;
      res    <= '0;
    end else begin
      if (state == ST_LOOP && !in_range && func_q == FN_CHECK_ALL) begin
        rr  <= rr + 1'b1;
        idx <= '0;
      end
      if ((state == ST_EVAL && !div_start && !res_load) ||
          (state == ST_ADV && !res_load) ||
          (state == ST_RADV && in_range && !expired)) begin
        idx <= idx + 1'b1;
      end
      if (state == ST_EVAL) begin
        lim_q <= l_cur;
      end
      if (res_load) begin
        res <= res_val;
      end
    end
    if (state == ST_DONE && out_free) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.exceeded     = out_q.exceeded;
  assign rsp.hit_interval = out_q.hit_interval;
  assign rsp.hit_resource = out_q.hit_resource;
  assign rsp.used_value   = out_q.used_value;
  assign rsp.limit_value  = out_q.limit_value;
  assign rsp.window_end   = out_q.window_end;

  `WQA_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy, "remainder unit did not start")
  `WQA_ASSERT_NOW(a_eval_in_range, state == ST_EVAL, idx < n_act, "interval walk overran")
  `WQA_ASSERT_NEXT(a_no_result_drop, rsp.valid && !rsp.ready, rsp.valid && $stable(out_q), "pending result overwritten")
  `WQA_ASSERT_NEXT(a_busy_after_req, accept, !req.ready, "request taken while busy")

endmodule
